// ----- rtl/cfbl_pkg.sv -----
// ----------------------------------------------------------------------------
// cfbl_pkg: shared types and constants of the chained free block list
// Word formats, kind and status codes, sizes, controller command and status.
// ----------------------------------------------------------------------------
package cfbl_pkg;

    localparam int LIST_ENTRIES = 32;
    localparam int AW           = $clog2(LIST_ENTRIES);     // list slot address
    localparam int CW           = $clog2(LIST_ENTRIES + 1); // counts up to LIST_ENTRIES

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_FILL  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_REFILL = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] block_number;
        logic [5:0]  word_index;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_block;
        logic [31:0] spill_word;
        logic        is_spill;
        logic        refill_needed;
        logic        last;
    } result_t;

    typedef struct packed {
        logic       load;
        logic       fill;
        logic       rd_slot;
        logic       alloc;
        logic       reject;
        logic [1:0] reject_status;
        logic       free_push;
        logic       spill_rd;
        logic       spill_out;
        logic       spill_end;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       refill_busy;
        logic       count_zero;
        logic       slot_zero;
        logic       rd_done;
    } ctl_sts_t;

endpackage

// ----- rtl/cfbl_ctrl.sv -----
// ----------------------------------------------------------------------------
// cfbl_ctrl: sequencer of the chained free block list
// One-hot state machine issuing datapath commands per word.
// ----------------------------------------------------------------------------
module cfbl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cfbl_pkg::ctl_sts_t sts,
    output cfbl_pkg::ctl_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_ALLOC = 4'b0100,
        S_SPILL = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                unique case (sts.kind)
                    cfbl_pkg::KIND_FILL: cmd.fill = 1'b1;
                    cfbl_pkg::KIND_NONE: ;
                    cfbl_pkg::KIND_ALLOC:
                    begin
                        priority if (sts.refill_busy)
                        begin
                            cmd.reject        = 1'b1;
                            cmd.reject_status = cfbl_pkg::ST_REFILL;
                        end
                        else if (sts.count_zero)
                        begin
                            cmd.reject        = 1'b1;
                            cmd.reject_status = cfbl_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.rd_slot = 1'b1;
                            state_next  = S_ALLOC;
                        end
                    end
                    cfbl_pkg::KIND_FREE:
                    begin
                        priority if (sts.refill_busy)
                        begin
                            cmd.reject        = 1'b1;
                            cmd.reject_status = cfbl_pkg::ST_REFILL;
                        end
                        else if (sts.slot_zero)
                        begin
                            cmd.spill_rd = 1'b1;
                            state_next   = S_SPILL;
                        end
                        else
                            cmd.free_push = 1'b1;
                    end
                endcase
            end
            S_ALLOC:
            begin
                cmd.alloc  = 1'b1;
                state_next = S_IDLE;
            end
            S_SPILL:
            begin
                cmd.spill_out = 1'b1;
                if (sts.rd_done)
                begin
                    cmd.spill_end = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                    cmd.spill_rd = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/cfbl_dp.sv -----
// ----------------------------------------------------------------------------
// cfbl_dp: datapath of the chained free block list
// List memory, free count, slot index, refill counter and result register.
// ----------------------------------------------------------------------------
module cfbl_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  cfbl_pkg::item_t    item,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_data,
    input  cfbl_pkg::ctl_cmd_t cmd,
    output cfbl_pkg::ctl_sts_t sts,
    output logic               done,
    output cfbl_pkg::result_t  result
);

    localparam logic [cfbl_pkg::AW-1:0] SLOT_LAST = cfbl_pkg::AW'(cfbl_pkg::LIST_ENTRIES - 1);
    localparam logic [cfbl_pkg::CW-1:0] CNT_FULL  = cfbl_pkg::CW'(cfbl_pkg::LIST_ENTRIES);

    logic [31:0] mem [cfbl_pkg::LIST_ENTRIES];
    logic [31:0] rdata_reg;

    cfbl_pkg::item_t   item_reg;
    cfbl_pkg::result_t rsp_reg, rsp_next;
    logic              done_reg, done_next;

    logic [31:0]               free_count_reg, free_count_next;
    logic [cfbl_pkg::AW-1:0]   next_slot_reg, next_slot_next;
    logic [cfbl_pkg::CW-1:0]   refill_left_reg, refill_left_next;
    logic [cfbl_pkg::CW-1:0]   rd_idx_reg, rd_idx_next;

    logic                      mem_we, mem_re;
    logic [cfbl_pkg::AW-1:0]   mem_wa, mem_ra;
    logic                      fill_in_range;
    logic                      link;

    assign fill_in_range = (int'(item_reg.word_index) < cfbl_pkg::LIST_ENTRIES);
    assign link          = (next_slot_reg == SLOT_LAST);

    assign sts.kind        = item_reg.kind;
    assign sts.refill_busy = (refill_left_reg != '0);
    assign sts.count_zero  = (free_count_reg == '0);
    assign sts.slot_zero   = (next_slot_reg == '0);
    assign sts.rd_done     = (rd_idx_reg == CNT_FULL);

    // memory port selection
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = item_reg.word_index[cfbl_pkg::AW-1:0];
        if (cmd.fill && fill_in_range)
            mem_we = 1'b1;
        if (cmd.free_push)
        begin
            mem_we = 1'b1;
            mem_wa = next_slot_reg - cfbl_pkg::AW'(1);
        end
        if (cmd.spill_end)
        begin
            mem_we = 1'b1;
            mem_wa = SLOT_LAST;
        end
        mem_re = cmd.rd_slot | cmd.spill_rd;
        mem_ra = cmd.spill_rd ? rd_idx_reg[cfbl_pkg::AW-1:0] : next_slot_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= item_reg.block_number;
        if (mem_re)
            rdata_reg <= mem[mem_ra];
    end

    always_comb
    begin
        free_count_next  = free_count_reg;
        next_slot_next   = next_slot_reg;
        refill_left_next = refill_left_reg;
        rd_idx_next      = rd_idx_reg;

        if (cfg_we)
            free_count_next = cfg_data;
        if (cmd.alloc)
        begin
            free_count_next = free_count_reg - 32'd1;
            if (link)
                refill_left_next = CNT_FULL;
            else
                next_slot_next = next_slot_reg + cfbl_pkg::AW'(1);
        end
        if (cmd.fill && (refill_left_reg != '0))
        begin
            refill_left_next = refill_left_reg - cfbl_pkg::CW'(1);
            if (refill_left_reg == cfbl_pkg::CW'(1))
                next_slot_next = '0;
        end
        if (cmd.free_push)
        begin
            free_count_next = free_count_reg + 32'd1;
            next_slot_next  = next_slot_reg - cfbl_pkg::AW'(1);
        end
        if (cmd.spill_end)
        begin
            free_count_next = free_count_reg + 32'd1;
            next_slot_next  = SLOT_LAST;
        end
        if (cmd.load)
            rd_idx_next = '0;
        if (cmd.spill_rd)
            rd_idx_next = rd_idx_reg + cfbl_pkg::CW'(1);
    end

    always_comb
    begin
        rsp_next  = '0;
        done_next = cmd.alloc | cmd.reject | cmd.free_push | cmd.spill_out;
        if (cmd.alloc)
        begin
            rsp_next.status        = cfbl_pkg::ST_OK;
            rsp_next.result_block  = rdata_reg;
            rsp_next.refill_needed = link;
            rsp_next.last          = 1'b1;
        end
        if (cmd.reject)
        begin
            rsp_next.status = cmd.reject_status;
            rsp_next.last   = 1'b1;
        end
        if (cmd.free_push)
        begin
            rsp_next.result_block = item_reg.block_number;
            rsp_next.last         = 1'b1;
        end
        if (cmd.spill_out)
        begin
            rsp_next.result_block = item_reg.block_number;
            rsp_next.spill_word   = rdata_reg;
            rsp_next.is_spill     = 1'b1;
            rsp_next.last         = sts.rd_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg  <= '0;
            next_slot_reg   <= SLOT_LAST;
            refill_left_reg <= '0;
            rd_idx_reg      <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            free_count_reg  <= free_count_next;
            next_slot_reg   <= next_slot_next;
            refill_left_reg <= refill_left_next;
            rd_idx_reg      <= rd_idx_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item;
        rsp_reg <= rsp_next;
    end

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

// ----- rtl/chained_free_block_list.sv -----
// ----------------------------------------------------------------------------
// chained_free_block_list: superblock-style chained free block list
// Sequence: fill and unused kinds give no word; a rejected alloc/free or a
//   plain free gives its word once the kind is decoded, an alloc after one
//   registered list read. A new word is taken only once busy is low again;
//   a spill holds busy while the whole list is read out, one spill word per
//   cycle through the single read port of the list memory. Results cannot
//   be stalled.
// Reset: free count 0, slot index LIST_ENTRIES - 1, no refill pending; the
//   list memory itself is not cleared and must be filled before use.
// ----------------------------------------------------------------------------
module chained_free_block_list (
    input  logic              clk,
    input  logic              rst_n,
    // command side: a word is taken when start is high and busy is low
    input  logic              start,
    output logic              busy,
    input  cfbl_pkg::item_t   item,
    // result side: one word per cycle while done is high
    output logic              done,
    output cfbl_pkg::result_t result,
    // configuration: initial free count, loaded straight into the counter
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [31:0]       cfg_data
);

    cfbl_pkg::ctl_cmd_t cmd;
    cfbl_pkg::ctl_sts_t sts;
    logic               cfg_we;

    // configuration is only taken between commands
    assign cfg_ready = ~busy;
    assign cfg_we    = cfg_valid & cfg_ready;

    // sequencer: one-hot FSM, decodes the latched kind against list status
    cfbl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // datapath: list memory, counters and the registered result word
    cfbl_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .done     (done),
        .result   (result)
    );

`ifndef SYNTHESIS
    // a taken command never answers in the very next cycle
    a_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result word one cycle after start");

    // the final word of a command leaves the block idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.last) |-> !busy)
        else $error("busy after final result word");

    // only spill words come without last, and only while still working
    a_spill_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last) |-> (busy && result.is_spill))
        else $error("non-final word outside a spill");

    // a rejection is always a single non-spill word
    a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != cfbl_pkg::ST_OK)) |-> (result.last && !result.is_spill))
        else $error("rejection word malformed");
`endif

endmodule

// ----- dv/chained_free_block_list_tb.sv -----
// ----------------------------------------------------------------------------
// chained_free_block_list_tb: self-checking bench for the free block list
// Drives allocate, free, fill and unused commands through the start/busy
// port and checks every result word against an in-bench model of the list,
// the slot index, the free count and refill tracking. Directed tests cover
// the count extremes, the link slot, refill and spill. Random phases then
// mix well-formed alloc/free/refill traffic with noise, at several
// free-count settings.
// ----------------------------------------------------------------------------
module chained_free_block_list_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;
    localparam int SETTLE_GAP   = 4;             // margin for fill/unused items, which give no word
    localparam int TAIL_CYCLES  = cfbl_pkg::LIST_ENTRIES + 8;
    localparam int AW           = cfbl_pkg::AW;

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    cfbl_pkg::item_t   cmd_item  = '0;
    logic              done;
    cfbl_pkg::result_t result_word;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [31:0]       cfg_data  = '0;

    chained_free_block_list u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (cmd_item),
        .done      (done),
        .result    (result_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Model of the list: its own copy of every piece of state
    // ------------------------------------------------------------------
    logic [31:0]   blocks_free;                  // free block counter
    logic [AW-1:0] take_slot;                    // next slot to hand out
    logic [6:0]    refill_words_left;            // fill words still owed to a refill
    logic [31:0]   list_copy [cfbl_pkg::LIST_ENTRIES];

    cfbl_pkg::result_t expected_words [$];       // words still to come, oldest first

    // Scoreboard and coverage tallies
    int          error_count    = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          items_sent     = 0;
    int          words_checked  = 0;
    int          spills_seen    = 0;
    int          refills_seen   = 0;
    int          fulls_seen     = 0;
    int          refill_blocked = 0;
    bit          no_gaps        = 1'b0;          // back-to-back mode for the sender

    function automatic cfbl_pkg::result_t make_word(logic [1:0] st, logic [31:0] blk,
                                                    logic [31:0] sw, logic sp, logic rf,
                                                    logic lst);
        cfbl_pkg::result_t w;
        w.status        = st;
        w.result_block  = blk;
        w.spill_word    = sw;
        w.is_spill      = sp;
        w.refill_needed = rf;
        w.last          = lst;
        return w;
    endfunction

    // Work out the words one accepted command causes and move the model on
    task automatic predict_list_words(cfbl_pkg::item_t it);
        logic [AW-1:0] slot;
        logic          link;
        slot = take_slot;
        case (it.kind)
            cfbl_pkg::KIND_FILL:
            begin
                if (it.word_index < cfbl_pkg::LIST_ENTRIES)
                    list_copy[it.word_index[AW-1:0]] = it.block_number;
                // every fill counts during a refill, even one that writes nothing
                if (refill_words_left != 0)
                begin
                    refill_words_left--;
                    if (refill_words_left == 0)
                        take_slot = '0;
                end
            end
            cfbl_pkg::KIND_NONE:
            begin
            end
            default:
            begin
                if (refill_words_left != 0)
                begin
                    // refill pending: alloc and free are turned away, nothing moves
                    expected_words.push_back(make_word(cfbl_pkg::ST_REFILL, '0, '0,
                                                       1'b0, 1'b0, 1'b1));
                    refill_blocked++;
                end
                else if (it.kind == cfbl_pkg::KIND_ALLOC)
                begin
                    if (blocks_free == 0)
                    begin
                        expected_words.push_back(make_word(cfbl_pkg::ST_FULL, '0, '0,
                                                           1'b0, 1'b0, 1'b1));
                        fulls_seen++;
                    end
                    else
                    begin
                        link = (slot == AW'(cfbl_pkg::LIST_ENTRIES - 1));
                        expected_words.push_back(make_word(cfbl_pkg::ST_OK, list_copy[slot],
                                                           '0, 1'b0, link, 1'b1));
                        if (link)
                        begin
                            refill_words_left = 7'(cfbl_pkg::LIST_ENTRIES);
                            refills_seen++;
                        end
                        else
                            take_slot = slot + AW'(1);
                        blocks_free--;
                    end
                end
                else
                begin
                    blocks_free++;               // wraps at the top of the range
                    if (slot == '0)
                    begin
                        // full list: every entry goes out, freed block becomes the link
                        for (int i = 0; i < cfbl_pkg::LIST_ENTRIES; i++)
                            expected_words.push_back(make_word(cfbl_pkg::ST_OK,
                                                               it.block_number,
                                                               list_copy[i], 1'b1, 1'b0,
                                                               i == cfbl_pkg::LIST_ENTRIES - 1));
                        take_slot = AW'(cfbl_pkg::LIST_ENTRIES - 1);
                        list_copy[cfbl_pkg::LIST_ENTRIES - 1] = it.block_number;
                        spills_seen++;
                    end
                    else
                    begin
                        take_slot = slot - AW'(1);
                        list_copy[take_slot] = it.block_number;
                        expected_words.push_back(make_word(cfbl_pkg::ST_OK, it.block_number,
                                                           '0, 1'b0, 1'b0, 1'b1));
                    end
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Command side. start stays high after a word is taken, so a following
    // word with no gap goes straight out; anything else that lets time pass
    // must lower start first (settle_list does).
    // ------------------------------------------------------------------
    task automatic issue_word(logic [1:0] kind, logic [31:0] blk, logic [5:0] idx);
        cfbl_pkg::item_t it;
        int              gap;
        it.kind         = kind;
        it.block_number = blk;
        it.word_index   = idx;
        gap = no_gaps ? 0 : int'($urandom_range(0, 12));
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        cmd_item <= it;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_list_words(it);
        if (kind != cfbl_pkg::KIND_NONE)
            items_sent++;
    endtask

    // Hold off until every expected word is in and the block has gone quiet
    task automatic settle_list();
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    // Config write; only called once the list has settled
    task automatic write_free_count(logic [31:0] value);
        int gap;
        gap = no_gaps ? 0 : int'($urandom_range(0, 12));
        repeat (gap) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid   <= 1'b0;
        blocks_free  = value;
    endtask

    function automatic logic [31:0] pick_block();
        int r;
        r = int'($urandom_range(0, 9));
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom();
    endfunction

    function automatic logic [5:0] pick_idx();
        return 6'($urandom());
    endfunction

    // ------------------------------------------------------------------
    // Result side: one word per done cycle, taken at the closing edge.
    // Each is matched against the oldest expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cfbl_pkg::result_t want;
        bit                bad;
        if (rst_n)
        begin
            if ($isunknown(done))
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("[%0d] done is unknown", cycle_count);
            end
            else if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("[%0d] unexpected word %p", cycle_count, result_word);
                end
                else
                begin
                    want = expected_words.pop_front();
                    words_checked++;
                    bad = (result_word.status        !== want.status)
                       || (result_word.result_block  !== want.result_block)
                       || (result_word.spill_word    !== want.spill_word)
                       || (result_word.is_spill      !== want.is_spill)
                       || (result_word.refill_needed !== want.refill_needed)
                       || (result_word.last          !== want.last);
                    if (bad)
                    begin
                        error_count++;
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("[%0d] mismatch exp st=%0d blk=%h sw=%h sp=%b rf=%b lst=%b",
                                     cycle_count, want.status, want.result_block,
                                     want.spill_word, want.is_spill, want.refill_needed,
                                     want.last);
                            $display("        got      st=%0d blk=%h sw=%h sp=%b rf=%b lst=%b",
                                     result_word.status, result_word.result_block,
                                     result_word.spill_word, result_word.is_spill,
                                     result_word.refill_needed, result_word.last);
                        end
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_words.size());
            $display("chained_free_block_list_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Count is zero out of reset: an alloc is refused before any list read
    task automatic test_empty_alloc();
        issue_word(cfbl_pkg::KIND_ALLOC, '1, 6'h3f);
        settle_list();
    endtask

    // Initial list load: every slot written, so no entry is ever read unset
    task automatic test_list_load();
        for (int i = 0; i < cfbl_pkg::LIST_ENTRIES; i++)
            issue_word(cfbl_pkg::KIND_FILL,
                       (i == 0) ? 32'h0 :
                       (i == cfbl_pkg::LIST_ENTRIES - 1) ? 32'hffff_ffff : $urandom(),
                       6'(i));
        settle_list();
    endtask

    // Top of the count range: one free wraps it to zero, alloc then refused
    task automatic test_count_wrap();
        write_free_count(32'hffff_ffff);
        issue_word(cfbl_pkg::KIND_FREE, 32'hffff_ffff, 6'h00);
        issue_word(cfbl_pkg::KIND_ALLOC, 32'h0, 6'h00);
        issue_word(cfbl_pkg::KIND_NONE, $urandom(), pick_idx());
        settle_list();
    endtask

    // Walk to the link slot, check refusals while refilling, then refill
    // with a few out-of-range slot numbers and an unused kind mixed in
    task automatic test_link_refill();
        write_free_count(32'd40);
        issue_word(cfbl_pkg::KIND_ALLOC, $urandom(), pick_idx());
        issue_word(cfbl_pkg::KIND_ALLOC, $urandom(), pick_idx());   // takes the link slot
        issue_word(cfbl_pkg::KIND_ALLOC, $urandom(), pick_idx());   // refused: refill pending
        issue_word(cfbl_pkg::KIND_FREE, 32'h1234_5678, pick_idx()); // refused too
        for (int i = 0; i < cfbl_pkg::LIST_ENTRIES; i++)
        begin
            if (i == 5)
                issue_word(cfbl_pkg::KIND_NONE, $urandom(), pick_idx());
            if (i == 3)
                issue_word(cfbl_pkg::KIND_FILL, $urandom(), 6'h3f);
            else if (i == 9)
                issue_word(cfbl_pkg::KIND_FILL, $urandom(), 6'(cfbl_pkg::LIST_ENTRIES));
            else
                issue_word(cfbl_pkg::KIND_FILL, pick_block(), 6'(i));
        end
        settle_list();
    endtask

    // Refill left the index at 0: the next free spills the whole list
    task automatic test_spill();
        issue_word(cfbl_pkg::KIND_FREE, 32'h0, 6'h00);
        issue_word(cfbl_pkg::KIND_FREE, 32'hffff_ffff, 6'h3f);
        issue_word(cfbl_pkg::KIND_ALLOC, $urandom(), pick_idx());
        issue_word(cfbl_pkg::KIND_FREE, $urandom(), pick_idx());
        settle_list();
    endtask

    // One random phase at a given count setting and alloc bias
    task automatic run_random_phase(logic [31:0] count_setting, int n_items, int alloc_pct);
        int         sent;
        int         roll;
        logic [1:0] kind;
        logic [5:0] idx;
        sent = 0;
        settle_list();
        no_gaps = ($urandom_range(0, 3) == 0);
        write_free_count(count_setting);
        while (sent < n_items)
        begin
            roll = int'($urandom_range(0, 99));
            if ($urandom_range(0, 99) < 85)
                idx = 6'($urandom_range(0, cfbl_pkg::LIST_ENTRIES - 1));
            else
                idx = pick_idx();
            if (refill_words_left != 0)
            begin
                // mostly a proper refill, now and then a refused command
                if (roll < 88)
                    kind = cfbl_pkg::KIND_FILL;
                else if (roll < 95)
                    kind = $urandom_range(0, 1) ? cfbl_pkg::KIND_ALLOC : cfbl_pkg::KIND_FREE;
                else
                    kind = cfbl_pkg::KIND_NONE;
            end
            else
            begin
                if (roll < 4)
                    kind = cfbl_pkg::KIND_NONE;
                else if (roll < 9)
                    kind = cfbl_pkg::KIND_FILL;
                else if ($urandom_range(0, 99) < alloc_pct)
                    kind = cfbl_pkg::KIND_ALLOC;
                else
                    kind = cfbl_pkg::KIND_FREE;
            end
            issue_word(kind, pick_block(), idx);
            if (kind != cfbl_pkg::KIND_NONE)
                sent++;
            // occasional full drain with the sender held off
            if ($urandom_range(0, 59) == 0)
                settle_list();
        end
    endtask

    // Random traffic across count settings, extremes included
    task automatic test_random();
        run_random_phase(32'd0,           30, 50);
        run_random_phase(32'hffff_ffff,   30, 80);
        run_random_phase(32'd6,           30, 75);
        run_random_phase($urandom(),      30, 20);
        run_random_phase(32'h8000_0000,   30, 85);
        run_random_phase(32'd1,           30, 60);
        run_random_phase($urandom(),      30, 50);
        run_random_phase(32'hffff_fffe,   30, 30);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        blocks_free       = '0;
        take_slot         = AW'(cfbl_pkg::LIST_ENTRIES - 1);
        refill_words_left = '0;
        foreach (list_copy[i])
            list_copy[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_alloc();
        test_list_load();
        test_count_wrap();
        test_link_refill();
        test_spill();
        test_random();

        settle_list();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
        begin
            error_count++;
            $display("%0d expected words never arrived", expected_words.size());
        end

        $display("covered %0d commands, %0d words checked: %0d spills, %0d refills,",
                 items_sent, words_checked, spills_seen, refills_seen);
        $display("  %0d refused as full, %0d refused during refill, %0d errors",
                 fulls_seen, refill_blocked, error_count);
        if (error_count == 0)
            $display("chained_free_block_list_tb: clean");
        else
            $display("chained_free_block_list_tb: errors");
        $finish;
    end

endmodule
